[src/ggps_pkg.sv]
`default_nettype none

package ggps_pkg;

    localparam int NUM_VERTICES = 26;
    localparam int VERT_W       = 5;
    localparam int WEIGHT_W     = 16;
    localparam int TABLE_DEPTH  = NUM_VERTICES * NUM_VERTICES;
    localparam int IDX_W        = $clog2(NUM_VERTICES);
    localparam int LEN_W        = $clog2(NUM_VERTICES + 1);
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);

    localparam int S_TDATA_W    = ((2 * VERT_W + WEIGHT_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((VERT_W + 7) / 8) * 8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic load_wr;
        logic init;
        logic scan_begin;
        logic scan_issue;
        logic push;
        logic pop;
        logic emit_begin;
        logic out_path;
        logic out_nf;
    } ggps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic src_ok;
        logic goal_hit;
        logic scan_last;
        logic have;
        logic len_one;
        logic emit_last;
    } ggps_sts_t;

endpackage

`default_nettype wire

[src/greedy_graph_path_search_top.sv]
// Operation: a load beat writes one edge weight; a search reads the table for each step (one
//   table read per candidate through the single read port of the weight table), runs at most
//   2N-1 steps, then gives one result beat per path vertex, one per cycle while m_tready is
//   high (N = 26 vertices). One search runs at a time: s_tready stays low until it is done.
// Reset: aresetn (synchronous, active low) starts a clearing pass over all N*N = 676 entries
//   of the weight table, during which s_tready stays low.
`default_nettype none

module greedy_graph_path_search_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input beats
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // src_vertex [4:0], dst_vertex [9:5], weight [25:10], zero pad above
    input  wire logic [ggps_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd: 0 load one edge weight, 1 run a search
    input  wire logic                              s_tuser,
    // Result beats
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // path_vertex [4:0], zero pad above
    output logic [ggps_pkg::M_TDATA_W-1:0]         m_tdata,
    // found
    output logic                                   m_tuser,
    // last result beat of a search
    output logic                                   m_tlast
);

    ggps_pkg::ggps_cmd_t               cmd;
    ggps_pkg::ggps_sts_t               sts;
    logic [ggps_pkg::VERT_W-1:0]       in_src;
    logic [ggps_pkg::VERT_W-1:0]       in_dst;
    logic [ggps_pkg::WEIGHT_W-1:0]     in_weight;
    logic [ggps_pkg::VERT_W-1:0]       out_vertex;

    // Unpack the input beat
    assign in_src    = s_tdata[ggps_pkg::VERT_W-1:0];
    assign in_dst    = s_tdata[2*ggps_pkg::VERT_W-1:ggps_pkg::VERT_W];
    assign in_weight = s_tdata[2*ggps_pkg::VERT_W+ggps_pkg::WEIGHT_W-1:2*ggps_pkg::VERT_W];

    // Controller: clearing pass, beat handshakes and the walk sequence
    ggps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: weight table, visited marks, path stack, candidate scan, result register
    ggps_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_src     (in_src),
        .in_dst     (in_dst),
        .in_weight  (in_weight),
        .out_vertex (out_vertex),
        .out_found  (m_tuser),
        .out_last   (m_tlast)
    );

    // Pack the result beat
    assign m_tdata = ggps_pkg::M_TDATA_W'(out_vertex);

    // A not-found result is always the only beat of its search
    a_notfound_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("not-found beat without last");

    // A found path only names real vertices
    a_vertex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> 32'(m_tdata[ggps_pkg::VERT_W-1:0]) < ggps_pkg::NUM_VERTICES)
        else $error("path vertex out of range");

    // A started search holds exactly the start vertex on its path
    a_search_init: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ggps_pkg::CMD_SEARCH) && sts.src_ok
        |=> sts.len_one)
        else $error("search did not start with a one-entry path");

endmodule

`default_nettype wire

[src/ggps_datapath.sv]
`default_nettype none

module ggps_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  ggps_pkg::ggps_cmd_t                  cmd,
    output ggps_pkg::ggps_sts_t                  sts,
    input  wire logic [ggps_pkg::VERT_W-1:0]     in_src,
    input  wire logic [ggps_pkg::VERT_W-1:0]     in_dst,
    input  wire logic [ggps_pkg::WEIGHT_W-1:0]   in_weight,
    output logic [ggps_pkg::VERT_W-1:0]          out_vertex,
    output logic                                 out_found,
    output logic                                 out_last
);

    // Edge weight table, row = source vertex
    logic [ggps_pkg::WEIGHT_W-1:0] table_mem [ggps_pkg::TABLE_DEPTH];

    logic [ggps_pkg::ADDR_W-1:0]       clr_addr_reg;
    logic [ggps_pkg::WEIGHT_W-1:0]     rd_data_reg;
    logic [ggps_pkg::IDX_W-1:0]        rd_idx_reg;
    logic                              rd_vld_reg;

    logic [ggps_pkg::VERT_W-1:0]       cur_reg;
    logic [ggps_pkg::VERT_W-1:0]       goal_reg;
    logic [ggps_pkg::ADDR_W-1:0]       base_reg;
    logic [ggps_pkg::IDX_W-1:0]        scan_idx_reg;
    logic [ggps_pkg::NUM_VERTICES-1:0] visited_reg;
    logic [ggps_pkg::VERT_W-1:0]       stack_reg [ggps_pkg::NUM_VERTICES];
    logic [ggps_pkg::LEN_W-1:0]        len_reg;
    logic [ggps_pkg::IDX_W-1:0]        emit_idx_reg;
    logic                              have_reg;
    logic [ggps_pkg::WEIGHT_W-1:0]     best_w_reg;
    logic [ggps_pkg::IDX_W-1:0]        best_idx_reg;

    logic                              src_ok;
    logic                              dst_ok;
    logic                              wr_en;
    logic [ggps_pkg::ADDR_W-1:0]       wr_addr;
    logic [ggps_pkg::WEIGHT_W-1:0]     wr_data;
    logic [ggps_pkg::ADDR_W-1:0]       rd_addr;
    logic                              cand;
    logic [ggps_pkg::LEN_W-1:0]        len_m2;
    logic [ggps_pkg::VERT_W-1:0]       pop_vertex;
    logic [ggps_pkg::VERT_W-1:0]       best_vertex;

    assign src_ok  = 32'(in_src) < ggps_pkg::NUM_VERTICES;
    assign dst_ok  = 32'(in_dst) < ggps_pkg::NUM_VERTICES;
    assign wr_en   = cmd.clr_wr || (cmd.load_wr && src_ok && dst_ok);
    assign wr_addr = cmd.clr_wr ? clr_addr_reg
                   : ggps_pkg::ADDR_W'(32'(in_src) * ggps_pkg::NUM_VERTICES + 32'(in_dst));
    assign wr_data = cmd.clr_wr ? '0 : in_weight;
    assign rd_addr = base_reg + ggps_pkg::ADDR_W'(scan_idx_reg);

    // Cheapest unvisited successor so far; strict compare keeps the lowest index on ties
    assign cand = rd_vld_reg && (rd_data_reg != '0) && !visited_reg[rd_idx_reg]
               && (!have_reg || (rd_data_reg < best_w_reg));

    // The stack holds the live path, so the parent of the top is the entry below it
    assign len_m2      = len_reg - ggps_pkg::LEN_W'(2);
    assign pop_vertex  = stack_reg[ggps_pkg::IDX_W'(len_m2)];
    assign best_vertex = ggps_pkg::VERT_W'(best_idx_reg);

    assign sts.clear_last = clr_addr_reg == ggps_pkg::ADDR_W'(ggps_pkg::TABLE_DEPTH - 1);
    assign sts.src_ok     = src_ok;
    assign sts.goal_hit   = cur_reg == goal_reg;
    assign sts.scan_last  = scan_idx_reg == ggps_pkg::IDX_W'(ggps_pkg::NUM_VERTICES - 1);
    assign sts.have       = have_reg;
    assign sts.len_one    = len_reg == ggps_pkg::LEN_W'(1);
    assign sts.emit_last  = (ggps_pkg::LEN_W'(emit_idx_reg) + ggps_pkg::LEN_W'(1)) == len_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_issue) begin
            rd_data_reg <= table_mem[rd_addr];
            rd_idx_reg  <= scan_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            rd_vld_reg   <= 1'b0;
            visited_reg  <= '0;
            len_reg      <= '0;
            cur_reg      <= '0;
            have_reg     <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_issue;
            if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + ggps_pkg::ADDR_W'(1);
            end
            if (cmd.init) begin
                visited_reg <= ggps_pkg::NUM_VERTICES'(1) << in_src;
                len_reg     <= ggps_pkg::LEN_W'(1);
                cur_reg     <= in_src;
            end
            if (cmd.scan_begin) begin
                have_reg <= 1'b0;
            end else if (cand) begin
                have_reg <= 1'b1;
            end
            if (cmd.push) begin
                visited_reg[best_idx_reg] <= 1'b1;
                len_reg                   <= len_reg + ggps_pkg::LEN_W'(1);
                cur_reg                   <= best_vertex;
            end
            if (cmd.pop) begin
                len_reg <= len_reg - ggps_pkg::LEN_W'(1);
                cur_reg <= pop_vertex;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            goal_reg     <= in_dst;
            stack_reg[0] <= in_src;
            base_reg     <= ggps_pkg::ADDR_W'(32'(in_src) * ggps_pkg::NUM_VERTICES);
        end
        if (cmd.scan_begin) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_issue) begin
            scan_idx_reg <= scan_idx_reg + ggps_pkg::IDX_W'(1);
        end
        if (cand) begin
            best_w_reg   <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end
        if (cmd.push) begin
            stack_reg[ggps_pkg::IDX_W'(len_reg)] <= best_vertex;
            base_reg <= ggps_pkg::ADDR_W'(32'(best_vertex) * ggps_pkg::NUM_VERTICES);
        end
        if (cmd.pop) begin
            base_reg <= ggps_pkg::ADDR_W'(32'(pop_vertex) * ggps_pkg::NUM_VERTICES);
        end
        if (cmd.emit_begin) begin
            emit_idx_reg <= '0;
        end else if (cmd.out_path) begin
            emit_idx_reg <= emit_idx_reg + ggps_pkg::IDX_W'(1);
        end
        if (cmd.out_path) begin
            out_vertex <= stack_reg[emit_idx_reg];
            out_found  <= 1'b1;
            out_last   <= sts.emit_last;
        end else if (cmd.out_nf) begin
            out_vertex <= '0;
            out_found  <= 1'b0;
            out_last   <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/ggps_ctrl.sv]
`default_nettype none

module ggps_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            s_cmd,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  ggps_pkg::ggps_sts_t  sts,
    output ggps_pkg::ggps_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_STEP   = 8'b0000_0100,
        ST_SCAN   = 8'b0000_1000,
        ST_WAIT   = 8'b0001_0000,
        ST_DECIDE = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_NOTF   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;
    logic   load_out;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_cmd == ggps_pkg::CMD_LOAD) begin
                        cmd.load_wr = 1'b1;
                    end else if (sts.src_ok) begin
                        cmd.init   = 1'b1;
                        state_next = ST_STEP;
                    end else begin
                        state_next = ST_NOTF;
                    end
                end
            end
            ST_STEP: begin
                if (sts.goal_hit) begin
                    cmd.emit_begin = 1'b1;
                    state_next     = ST_EMIT;
                end else begin
                    cmd.scan_begin = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (sts.have) begin
                    cmd.push   = 1'b1;
                    state_next = ST_STEP;
                end else if (sts.len_one) begin
                    state_next = ST_NOTF;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_path = 1'b1;
                    load_out     = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NOTF: begin
                if (out_free) begin
                    cmd.out_nf = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire
